>>> design/y86_pkg.sv
// shared types and codes for the y86 execute core
package y86_pkg;
    localparam int unsigned STACK_REG = 4;

    typedef enum logic [3:0] {
        K_HALT  = 4'd0,
        K_NOP   = 4'd1,
        K_MOVE  = 4'd2,
        K_IRMOV = 4'd3,
        K_STORE = 4'd4,
        K_LOAD  = 4'd5,
        K_ALU   = 4'd6,
        K_JUMP  = 4'd7,
        K_CALL  = 4'd8,
        K_RET   = 4'd9,
        K_PUSH  = 4'd10,
        K_POP   = 4'd11
    } t_kind;

    typedef enum logic [2:0] {
        C_ALWAYS = 3'd0,
        C_LE     = 3'd1,
        C_L      = 3'd2,
        C_E      = 3'd3,
        C_NE     = 3'd4,
        C_GE     = 3'd5,
        C_G      = 3'd6
    } t_cond;

    typedef enum logic [2:0] {
        A_ADD = 3'd0,
        A_SUB = 3'd1,
        A_AND = 3'd2,
        A_XOR = 3'd3
    } t_alu;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    // one memory access request from the control unit
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [31:0] addr;
        logic [31:0] wdata;
    } t_mem_req;
endpackage

>>> design/y86_instruction_execute_core.sv
// y86 execute core: control, register file, flags and data memory
// Usage: one already-fetched instruction is an item on the input channel
// (i_valid, o_stall and the decoded fields). Each item yields exactly one
// result item on the output channel (o_valid, i_stall, o_next_pc etc).
// An accepted item enters the execute state; its result is registered at
// the end of that state and held in the output state until taken. The data
// memory read is issued at the accepting edge; registers, flags and memory
// are written at the end of the execute cycle. An item passes the execute
// and output states before the next is accepted; i_stall holds it in output.
// One item is in work at a time:
// o_stall is high while an item executes or its result is not yet taken.
// Reset: a clearing sweep writes zero to every data memory byte, one byte a
// cycle; o_stall stays high meanwhile. Registers, flags and the halted mark
// clear at once. After a halt every item is ignored and reports halted with
// its fall-through address.
// A stalled result holds its values until taken.
module y86_instruction_execute_core #(
    parameter int unsigned MEM_BYTES = 4096,
    parameter int unsigned NUM_REGS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_kind,
    input  logic [2:0]  i_func,
    input  logic [2:0]  i_reg_a,
    input  logic [2:0]  i_reg_b,
    input  logic [31:0] i_immediate,
    input  logic [31:0] i_fall_through_pc,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_next_pc,
    output logic        o_halted_now,
    output logic        o_zero_flag,
    output logic        o_sign_flag,
    output logic        o_overflow_flag,
    output logic        o_condition_held,
    output logic [31:0] o_written_value
);
    localparam int unsigned AW = $clog2(MEM_BYTES);
    localparam int unsigned RW = $clog2(NUM_REGS);

    y86_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_clr;
    logic [31:0]   r_regs [NUM_REGS];
    logic          r_zf, r_sf, r_of, r_halt;
    logic [3:0]    r_kind;
    logic [2:0]    r_func;
    logic [RW-1:0] r_ra, r_rb;
    logic [31:0]   r_imm, r_fall;

    logic [31:0] va, vb, sp, rdata;
    logic [31:0] n_pc, n_wv, alu_v;
    logic        n_held, cond, lt, alu_ok;
    logic        rf_we, sp_we, fl_we;
    logic [RW-1:0] rf_wa;
    logic [31:0] rf_wd, sp_wd;
    logic        accept;
    y86_pkg::t_mem_req req;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != y86_pkg::S_IDLE);
    assign o_valid = (r_state == y86_pkg::S_OUT);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            y86_pkg::S_CLEAR: if (r_clr == AW'(MEM_BYTES - 1)) n_state = y86_pkg::S_IDLE;
            y86_pkg::S_IDLE:  if (accept) n_state = y86_pkg::S_EXEC;
            y86_pkg::S_EXEC:  n_state = y86_pkg::S_OUT;
            y86_pkg::S_OUT:   if (!i_stall) n_state = y86_pkg::S_IDLE;
            default:          n_state = y86_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= y86_pkg::S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == y86_pkg::S_CLEAR) r_clr <= r_clr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_func <= i_func;
            r_ra   <= RW'(i_reg_a);
            r_rb   <= RW'(i_reg_b);
            r_imm  <= i_immediate;
            r_fall <= i_fall_through_pc;
        end
    end

    assign va = r_regs[r_ra];
    assign vb = r_regs[r_rb];
    assign sp = r_regs[RW'(y86_pkg::STACK_REG)];

    // read request is issued from the incoming item at the idle->exec edge
    always_comb begin
        req = '0;
        if (r_state == y86_pkg::S_IDLE && accept && !r_halt) begin
            unique case (y86_pkg::t_kind'(i_kind))
                y86_pkg::K_LOAD: begin
                    req.rd = 1'b1;
                    req.addr = r_regs[RW'(i_reg_b)] + i_immediate;
                end
                y86_pkg::K_RET, y86_pkg::K_POP: begin
                    req.rd = 1'b1;
                    req.addr = sp;
                end
                default: req = '0;
            endcase
        end else if (r_state == y86_pkg::S_EXEC && !r_halt) begin
            unique case (y86_pkg::t_kind'(r_kind))
                y86_pkg::K_STORE: begin
                    req.wr = 1'b1; req.addr = vb + r_imm; req.wdata = va;
                end
                y86_pkg::K_CALL: begin
                    req.wr = 1'b1; req.addr = sp - 32'd4; req.wdata = r_fall;
                end
                y86_pkg::K_PUSH: begin
                    req.wr = 1'b1; req.addr = sp - 32'd4; req.wdata = va;
                end
                default: req = '0;
            endcase
        end
    end

    y86_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
        .i_clk      (i_clk),
        .i_clr      (r_state == y86_pkg::S_CLEAR),
        .i_clr_addr (r_clr),
        .i_req      (req),
        .o_rdata    (rdata)
    );

    assign lt = r_sf ^ r_of;
    always_comb begin
        unique case (y86_pkg::t_cond'(r_func))
            y86_pkg::C_ALWAYS: cond = 1'b1;
            y86_pkg::C_LE:     cond = r_zf | lt;
            y86_pkg::C_L:      cond = lt;
            y86_pkg::C_E:      cond = r_zf;
            y86_pkg::C_NE:     cond = !r_zf;
            y86_pkg::C_GE:     cond = !lt;
            y86_pkg::C_G:      cond = !(r_zf | lt);
            default:           cond = 1'b0;
        endcase
    end

    logic of_v;
    always_comb begin
        alu_ok = 1'b1;
        of_v   = 1'b0;
        unique case (y86_pkg::t_alu'(r_func))
            y86_pkg::A_ADD: begin
                alu_v = vb + va;
                of_v  = (va[31] == vb[31]) && (alu_v[31] != va[31]);
            end
            y86_pkg::A_SUB: begin
                alu_v = vb - va;
                of_v  = (vb[31] != va[31]) && (alu_v[31] != vb[31]);
            end
            y86_pkg::A_AND: alu_v = vb & va;
            y86_pkg::A_XOR: alu_v = vb ^ va;
            default: begin
                alu_v  = '0;
                alu_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_pc = r_fall; n_held = 1'b0; n_wv = '0;
        rf_we = 1'b0; rf_wa = r_rb; rf_wd = '0;
        sp_we = 1'b0; sp_wd = '0; fl_we = 1'b0;
        if (!r_halt) begin
            unique case (y86_pkg::t_kind'(r_kind))
                y86_pkg::K_MOVE: if (cond) begin
                    rf_we = 1'b1; rf_wd = va; n_held = 1'b1; n_wv = va;
                end
                y86_pkg::K_IRMOV: begin
                    rf_we = 1'b1; rf_wd = r_imm; n_wv = r_imm;
                end
                y86_pkg::K_STORE: n_wv = va;
                y86_pkg::K_LOAD: begin
                    rf_we = 1'b1; rf_wa = r_ra; rf_wd = rdata; n_wv = rdata;
                end
                y86_pkg::K_ALU: if (alu_ok) begin
                    rf_we = 1'b1; rf_wd = alu_v; n_wv = alu_v; fl_we = 1'b1;
                end
                y86_pkg::K_JUMP: if (cond) begin
                    n_pc = r_imm; n_held = 1'b1;
                end
                y86_pkg::K_CALL: begin
                    sp_we = 1'b1; sp_wd = sp - 32'd4; n_pc = r_imm; n_wv = r_fall;
                end
                y86_pkg::K_RET: begin
                    sp_we = 1'b1; sp_wd = sp + 32'd4; n_pc = rdata; n_wv = sp + 32'd4;
                end
                y86_pkg::K_PUSH: begin
                    sp_we = 1'b1; sp_wd = sp - 32'd4; n_wv = va;
                end
                y86_pkg::K_POP: begin
                    sp_we = 1'b1; sp_wd = sp + 32'd4;
                    rf_we = 1'b1; rf_wa = r_ra; rf_wd = rdata; n_wv = rdata;
                end
                default: n_wv = '0;
            endcase
        end
    end

    // pop into the stack pointer: the popped value is written last and wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_regs[i] <= '0;
            r_zf <= 1'b0; r_sf <= 1'b0; r_of <= 1'b0; r_halt <= 1'b0;
        end else if (r_state == y86_pkg::S_EXEC) begin
            if (sp_we) r_regs[RW'(y86_pkg::STACK_REG)] <= sp_wd;
            if (rf_we) r_regs[rf_wa] <= rf_wd;
            if (fl_we) begin
                r_zf <= (alu_v == 32'd0);
                r_sf <= alu_v[31];
                r_of <= of_v;
            end
            if (!r_halt && r_kind == y86_pkg::K_HALT) r_halt <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == y86_pkg::S_EXEC) begin
            o_next_pc        <= n_pc;
            o_condition_held <= n_held;
            o_written_value  <= n_wv;
        end
    end

    assign o_halted_now    = r_halt;
    assign o_zero_flag     = r_zf;
    assign o_sign_flag     = r_sf;
    assign o_overflow_flag = r_of;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != y86_pkg::S_IDLE) |-> !accept) else $error("accept while busy");
    a_exec_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == y86_pkg::S_EXEC) |=> o_valid) else $error("missing result");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt) else $error("halt mark lost");
    a_no_mem_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(req.rd && req.wr)) else $error("read and write together");
endmodule

>>> design/y86_dmem.sv
// byte-addressed data memory, four byte lanes, wrapping addresses, clear sweep
module y86_dmem #(
    parameter int unsigned MEM_BYTES = 4096
) (
    input  logic              i_clk,
    input  logic              i_clr,
    input  logic [$clog2(MEM_BYTES)-1:0] i_clr_addr,
    input  y86_pkg::t_mem_req i_req,
    output logic [31:0]       o_rdata
);
    localparam int unsigned AW    = $clog2(MEM_BYTES);
    localparam int unsigned LINES = MEM_BYTES / 4;

    // MEM_BYTES is a power of two, so wrapping keeps the low address bits
    logic [1:0]    w_k     [4];
    logic [31:0]   w_sum   [4];
    logic [31:0]   w_shift [4];
    logic [AW-3:0] w_line  [4];
    logic [7:0]    w_wbyte [4];
    logic [7:0]    r_rbyte [4];
    logic [1:0]    r_ofs;

    // lane l holds byte (l - addr) mod 4 of the word at line (addr + that byte) / 4
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            w_k[l]     = 2'(l) - i_req.addr[1:0];
            w_sum[l]   = i_req.addr + {30'd0, w_k[l]};
            w_line[l]  = w_sum[l][AW-1:2];
            w_shift[l] = i_req.wdata >> {w_k[l], 3'b000};
            w_wbyte[l] = w_shift[l][7:0];
        end
    end

    // one address per lane a cycle, shared by read and write; clearing one byte a cycle
    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [7:0] r_bank [LINES];

        always_ff @(posedge i_clk) begin
            if (i_clr) begin
                if (i_clr_addr[1:0] == 2'(l)) r_bank[i_clr_addr[AW-1:2]] <= 8'd0;
            end else if (i_req.wr) begin
                r_bank[w_line[l]] <= w_wbyte[l];
            end
            r_rbyte[l] <= r_bank[w_line[l]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ofs <= i_req.addr[1:0];
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_rdata[8*i +: 8] = r_rbyte[2'(r_ofs + 2'(i))];
        end
    end
endmodule

>>> sim/y86_execute_checker.sv
// result checker for the y86 execute core: watches both channels and predicts each result
`timescale 1ns / 100ps
module y86_execute_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [3:0]  i_kind,
    input  logic [2:0]  i_func,
    input  logic [2:0]  i_reg_a,
    input  logic [2:0]  i_reg_b,
    input  logic [31:0] i_immediate,
    input  logic [31:0] i_fall_through_pc,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_next_pc,
    input  logic        i_halted_now,
    input  logic        i_zero_flag,
    input  logic        i_sign_flag,
    input  logic        i_overflow_flag,
    input  logic        i_condition_held,
    input  logic [31:0] i_written_value,
    output int          o_errors,
    output int          o_pending
);
    localparam int unsigned MEM_BYTES = 4096;

    typedef struct {
        logic [31:0] next_pc;
        logic        halted;
        logic        zf;
        logic        sf;
        logic        of;
        logic        held;
        logic [31:0] written;
    } t_exec_result;

    logic [31:0]  gpr [8];
    logic         flag_z, flag_s, flag_o, halted;
    logic [7:0]   dmem [MEM_BYTES];
    t_exec_result expected_results [$];

    function automatic logic cond_true(logic [2:0] f);
        logic lt;
        lt = flag_s ^ flag_o;
        case (y86_pkg::t_cond'(f))
            y86_pkg::C_ALWAYS: return 1'b1;
            y86_pkg::C_LE:     return flag_z | lt;
            y86_pkg::C_L:      return lt;
            y86_pkg::C_E:      return flag_z;
            y86_pkg::C_NE:     return !flag_z;
            y86_pkg::C_GE:     return !lt;
            y86_pkg::C_G:      return !(flag_z | lt);
            default:           return 1'b0;
        endcase
    endfunction

    function automatic logic [31:0] read_word(logic [31:0] addr);
        logic [31:0] v;
        logic [31:0] a;
        v = '0;
        for (int i = 0; i < 4; i++) begin
            a = addr + i;
            v[8*i +: 8] = dmem[a % MEM_BYTES];
        end
        return v;
    endfunction

    task automatic write_word(logic [31:0] addr, logic [31:0] v);
        logic [31:0] a;
        for (int i = 0; i < 4; i++) begin
            a = addr + i;
            dmem[a % MEM_BYTES] = v[8*i +: 8];
        end
    endtask

    task automatic execute(input logic [3:0] kind, input logic [2:0] func,
                           input logic [2:0] ra, input logic [2:0] rb,
                           input logic [31:0] imm, input logic [31:0] fall,
                           output t_exec_result r);
        logic [31:0] va, vb, sp, v;
        r.next_pc = fall;
        r.held = 1'b0;
        r.written = '0;
        if (!halted) begin
            va = gpr[ra];
            vb = gpr[rb];
            sp = gpr[y86_pkg::STACK_REG];
            case (kind)
                y86_pkg::K_HALT: halted = 1'b1;
                y86_pkg::K_MOVE: begin
                    if (cond_true(func)) begin
                        gpr[rb] = va;
                        r.held = 1'b1;
                        r.written = va;
                    end
                end
                y86_pkg::K_IRMOV: begin
                    gpr[rb] = imm;
                    r.written = imm;
                end
                y86_pkg::K_STORE: begin
                    write_word(vb + imm, va);
                    r.written = va;
                end
                y86_pkg::K_LOAD: begin
                    v = read_word(vb + imm);
                    gpr[ra] = v;
                    r.written = v;
                end
                y86_pkg::K_ALU: begin
                    if (func <= y86_pkg::A_XOR) begin
                        case (y86_pkg::t_alu'(func))
                            y86_pkg::A_ADD: begin
                                v = vb + va;
                                flag_o = (va[31] == vb[31]) && (v[31] != va[31]);
                            end
                            y86_pkg::A_SUB: begin
                                v = vb - va;
                                flag_o = (va[31] != vb[31]) && (v[31] != vb[31]);
                            end
                            y86_pkg::A_AND: begin
                                v = vb & va;
                                flag_o = 1'b0;
                            end
                            default: begin
                                v = vb ^ va;
                                flag_o = 1'b0;
                            end
                        endcase
                        flag_z = (v == 0);
                        flag_s = v[31];
                        gpr[rb] = v;
                        r.written = v;
                    end
                end
                y86_pkg::K_JUMP: begin
                    if (cond_true(func)) begin
                        r.next_pc = imm;
                        r.held = 1'b1;
                    end
                end
                y86_pkg::K_CALL: begin
                    write_word(sp - 4, fall);
                    gpr[y86_pkg::STACK_REG] = sp - 4;
                    r.next_pc = imm;
                    r.written = fall;
                end
                y86_pkg::K_RET: begin
                    r.next_pc = read_word(sp);
                    gpr[y86_pkg::STACK_REG] = sp + 4;
                    r.written = sp + 4;
                end
                y86_pkg::K_PUSH: begin
                    write_word(sp - 4, va);
                    gpr[y86_pkg::STACK_REG] = sp - 4;
                    r.written = va;
                end
                y86_pkg::K_POP: begin
                    v = read_word(sp);
                    gpr[y86_pkg::STACK_REG] = sp + 4;
                    // popped value wins when popping into the stack pointer
                    gpr[ra] = v;
                    r.written = v;
                end
                default: ;
            endcase
        end
        r.halted = halted;
        r.zf = flag_z;
        r.sf = flag_s;
        r.of = flag_o;
    endtask

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_exec_result r;
        if (!i_rst_n) begin
            foreach (gpr[i]) gpr[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            flag_z = 0;
            flag_s = 0;
            flag_o = 0;
            halted = 0;
            o_errors = 0;
            expected_results.delete();
        end else begin
            if (i_valid && !i_stall_in) begin
                execute(i_kind, i_func, i_reg_a, i_reg_b, i_immediate, i_fall_through_pc, r);
                expected_results.push_back(r);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report("unexpected item", i_next_pc, '0);
                end else begin
                    r = expected_results.pop_front();
                    if (i_next_pc !== r.next_pc) report("next_pc", i_next_pc, r.next_pc);
                    if (i_halted_now !== r.halted) report("halted_now", i_halted_now, r.halted);
                    if (i_zero_flag !== r.zf) report("zero_flag", i_zero_flag, r.zf);
                    if (i_sign_flag !== r.sf) report("sign_flag", i_sign_flag, r.sf);
                    if (i_overflow_flag !== r.of)
                        report("overflow_flag", i_overflow_flag, r.of);
                    if (i_condition_held !== r.held)
                        report("condition_held", i_condition_held, r.held);
                    if (i_written_value !== r.written)
                        report("written_value", i_written_value, r.written);
                end
            end
        end
        o_pending = expected_results.size();
    end
endmodule

>>> sim/tb_top.sv
// testbench top for the y86 execute core: stimulus, idling and verdict
`timescale 1ns / 100ps
module tb_top;
    localparam int PHASE_ITEMS = 640;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [3:0]  i_kind = '0;
    logic [2:0]  i_func = '0;
    logic [2:0]  i_reg_a = '0;
    logic [2:0]  i_reg_b = '0;
    logic [31:0] i_immediate = '0;
    logic [31:0] i_fall_through_pc = '0;
    logic        o_valid;
    logic        i_stall = 1;
    logic [31:0] o_next_pc;
    logic        o_halted_now, o_zero_flag, o_sign_flag, o_overflow_flag;
    logic        o_condition_held;
    logic [31:0] o_written_value;
    int          fail_count, pending;
    int          tx_idle, rx_idle;
    int          items_sent = 0;
    int          hold_left = 0;
    logic        hold_done = 0;
    int          quiet_cycles = 0;

    always #1 i_clk = ~i_clk;

    y86_instruction_execute_core dut (.*);

    y86_execute_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall),
        .i_kind(i_kind), .i_func(i_func), .i_reg_a(i_reg_a), .i_reg_b(i_reg_b),
        .i_immediate(i_immediate), .i_fall_through_pc(i_fall_through_pc),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_next_pc(o_next_pc), .i_halted_now(o_halted_now),
        .i_zero_flag(o_zero_flag), .i_sign_flag(o_sign_flag),
        .i_overflow_flag(o_overflow_flag), .i_condition_held(o_condition_held),
        .i_written_value(o_written_value),
        .o_errors(fail_count), .o_pending(pending)
    );

    // receiver: random stall plus one long hold-off while the sender keeps offering
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (!hold_done && items_sent == 150) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle);
        end
    end

    // watchdog on cycles with no accepted item on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send(logic [3:0] kind, logic [2:0] func, logic [2:0] ra,
                        logic [2:0] rb, logic [31:0] imm, logic [31:0] fall);
        while ($urandom_range(99) < tx_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_kind <= kind;
        i_func <= func;
        i_reg_a <= ra;
        i_reg_b <= rb;
        i_immediate <= imm;
        i_fall_through_pc <= fall;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_random();
        logic [3:0]  kind;
        logic [2:0]  func;
        logic [31:0] imm;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 4) kind = 4'($urandom_range(15, 12));
        else if (pick < 8) kind = y86_pkg::K_NOP;
        else kind = 4'($urandom_range(y86_pkg::K_POP, y86_pkg::K_MOVE));
        func = (kind == y86_pkg::K_ALU && $urandom_range(9) > 1) ? 3'($urandom_range(3))
                                                                   : 3'($urandom);
        imm = $urandom;
        // mostly short displacements so loads find earlier stores
        if ((kind == y86_pkg::K_STORE || kind == y86_pkg::K_LOAD) && $urandom_range(3) != 0)
            imm = $urandom_range(64);
        // sometimes load the stack pointer with an address inside the memory
        if (kind == y86_pkg::K_IRMOV && $urandom_range(3) == 0) begin
            send(y86_pkg::K_IRMOV, 3'($urandom), 3'($urandom), 3'(y86_pkg::STACK_REG),
                 $urandom_range(4095), $urandom);
        end else begin
            send(kind, func, 3'($urandom), 3'($urandom), imm, $urandom);
        end
    endtask

    initial begin
        tx_idle = 25;
        rx_idle = 48;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: overflow edges, all conditions, wrapped accesses, stack ops
        send(y86_pkg::K_IRMOV, 3'd0, 3'd0, 3'd0, 32'h7fff_ffff, 32'h0000_0004);
        send(y86_pkg::K_IRMOV, 3'd0, 3'd0, 3'd1, 32'h0000_0001, 32'hffff_fffc);
        send(y86_pkg::K_ALU, y86_pkg::A_ADD, 3'd1, 3'd0, 32'h0, 32'h10);
        for (int c = 0; c < 8; c++)
            send(y86_pkg::K_JUMP, 3'(c), 3'd0, 3'd0, 32'hffff_ffff, 32'h20);
        send(y86_pkg::K_MOVE, 3'd7, 3'd1, 3'd2, 32'h0, 32'h24);
        send(y86_pkg::K_MOVE, y86_pkg::C_L, 3'd1, 3'd2, 32'h0, 32'h28);
        send(y86_pkg::K_ALU, 3'd5, 3'd1, 3'd2, 32'h0, 32'h2c);
        send(y86_pkg::K_ALU, y86_pkg::A_SUB, 3'd0, 3'd2, 32'h0, 32'h30);
        send(y86_pkg::K_ALU, y86_pkg::A_AND, 3'd2, 3'd2, 32'h0, 32'h34);
        send(y86_pkg::K_ALU, y86_pkg::A_XOR, 3'd0, 3'd0, 32'h0, 32'h38);
        send(4'd13, 3'd0, 3'd0, 3'd0, 32'h0, 32'h3c);
        send(y86_pkg::K_STORE, 3'd0, 3'd1, 3'd0, 32'hffff_fffe, 32'h40);
        send(y86_pkg::K_LOAD, 3'd0, 3'd3, 3'd5, 32'hffff_fffe, 32'h44);
        send(y86_pkg::K_PUSH, 3'd0, 3'd4, 3'd0, 32'h0, 32'h48);
        send(y86_pkg::K_CALL, 3'd0, 3'd0, 3'd0, 32'h0000_0100, 32'hdead_beef);
        send(y86_pkg::K_RET, 3'd0, 3'd0, 3'd0, 32'h0, 32'h50);
        send(y86_pkg::K_POP, 3'd0, 3'd4, 3'd0, 32'h0, 32'h54);

        for (int p = 0; p < 3; p++) begin
            tx_idle = (p == 0) ? 25 : (p == 1) ? 48 : 0;
            rx_idle = (p == 0) ? 48 : (p == 1) ? 25 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) send_random();
        end

        // halt, then items that must be ignored
        send(y86_pkg::K_HALT, 3'd0, 3'd0, 3'd0, 32'h0, 32'h1000);
        for (int n = 0; n < 6; n++) send_random();
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

>>> sim.f
design/y86_pkg.sv
design/y86_dmem.sv
design/y86_instruction_execute_core.sv
sim/y86_execute_checker.sv
sim/tb_top.sv
